// ----- sv/aes_pkg.sv -----
// ---------------------------------------------------------------------------
// AES-128 package
// S-box, GF(2^8) doubling, round transforms and key schedule step.
// ---------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned MixRounds = 9;

  typedef logic [127:0] block_t;

  // config register indexes
  localparam logic [0:0] CfgKeyHigh = 1'b0;
  localparam logic [0:0] CfgKeyLow  = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte i of a block sits in bits 127-8i -: 8
  function automatic logic [7:0] get_byte(block_t b, int unsigned i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] gf_double(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      t[127 - 32*c -: 8]  = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32*c -: 8]  = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
      t[111 - 32*c -: 8]  = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
      t[103 - 32*c -: 8]  = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
    end
    return t;
  endfunction

  function automatic block_t next_key(block_t k, logic [7:0] rcon);
    logic [31:0] w [4];
    logic [31:0] t;
    block_t n;
    for (int i = 0; i < 4; i++) begin
      w[i] = k[127 - 32*i -: 32];
    end
    t = {SBOX[w[3][23:16]] ^ rcon, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    n = {w[0], w[1], w[2], w[3]};
    return n;
  endfunction

  // round constant for round r (1..10)
  function automatic logic [7:0] rcon_of(int unsigned r);
    logic [7:0] c;
    c = 8'h01;
    for (int unsigned i = 1; i < NumRounds; i++) begin
      if (i < r) c = gf_double(c);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/aes_round.sv -----
// ---------------------------------------------------------------------------
// AES round stage
// One cipher round plus the matching key schedule step, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module aes_round #(
  parameter int unsigned Round = 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire aes_pkg::block_t in_state,
  input  wire aes_pkg::block_t in_key,
  output      logic           out_valid,
  output      aes_pkg::block_t out_state,
  output      aes_pkg::block_t out_key
);
  import aes_pkg::*;

  block_t key_next;
  block_t state_next;
  block_t ss;

  always_comb begin
    key_next = next_key(in_key, rcon_of(Round));
    ss = sub_shift(in_state);
    if (Round <= MixRounds) begin
      state_next = mix_columns(ss) ^ key_next;
    end else begin
      state_next = ss ^ key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_state <= state_next;
      out_key   <= key_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/aes128_block_encrypt_unit.sv -----
// ---------------------------------------------------------------------------
// AES-128 block encrypt unit
// Fully unrolled pipeline: whitening stage then ten round stages.
// ---------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_axis    in   tvalid/tready      tdata = plain_high, plain_low
// m_axis    out  tvalid/tready      tdata = cipher_high, cipher_low
// cfg       in   cfg_we             cfg_index, cfg_data (key_high, key_low)
//
// One block per cycle while m_axis does not stall; the pipeline has eleven register stages.
// The key is captured with each block and travels along its pipeline slot.
// Reset clears valid bits and the key registers.
// A stall on m_axis freezes the whole pipeline; tready follows m_axis_tready
// or an empty output slot.
`default_nettype none

module aes128_block_encrypt_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // plain_high[63:0], plain_low[127:64]
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [127:0] m_axis_tdata,   // cipher_high[63:0], cipher_low[127:64]
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  import aes_pkg::*;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        en;

  logic   v   [NumRounds + 1];
  block_t st  [NumRounds + 1];
  block_t rk  [NumRounds + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgKeyHigh: key_high <= cfg_data;
        CfgKeyLow:  key_low  <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign en = m_axis_tready || !v[NumRounds];
  assign s_axis_tready = en;

  // initial AddRoundKey
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= s_axis_tvalid;
    end
    if (en) begin
      st[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ {key_high, key_low};
      rk[0] <= {key_high, key_low};
    end
  end

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round #(.Round(r)) u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v[r-1]),
      .in_state  (st[r-1]),
      .in_key    (rk[r-1]),
      .out_valid (v[r]),
      .out_state (st[r]),
      .out_key   (rk[r])
    );
  end

  assign m_axis_tvalid = v[NumRounds];
  assign m_axis_tdata  = {st[NumRounds][63:0], st[NumRounds][127:64]};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("pipeline stalled with empty output");
  a_adv: assert property (@(posedge clk) disable iff (rst)
    en && v[NumRounds-1] |=> m_axis_tvalid)
    else $error("block lost at last stage");

endmodule

`default_nettype wire

// ----- tb/aes128_encrypt_checker.sv -----
// ---------------------------------------------------------------------------
// AES-128 encrypt checker
// Tracks the key writes, computes the ciphertext of each accepted plaintext
// and compares it with the block's results in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module aes128_encrypt_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  import aes_pkg::*;

  logic [127:0] cipher_key;
  logic [127:0] cipher_q[$];

  function automatic logic [7:0] xt(logic [7:0] b);
    return (b << 1) ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] encrypt_block(logic [127:0] pt, logic [127:0] k);
    logic [7:0] st[16], rk[16], t[16], tk[4], rc, a0, a1, a2, a3;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      st[i] = pt[127-8*i -: 8] ^ k[127-8*i -: 8];
      rk[i] = k[127-8*i -: 8];
    end
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          t[c*4+w] = SBOX[st[((c+w)%4)*4+w]];
      st = t;
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          st[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
          st[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
          st[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
          st[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
      end
      tk[0] = SBOX[rk[13]] ^ rc; tk[1] = SBOX[rk[14]];
      tk[2] = SBOX[rk[15]];      tk[3] = SBOX[rk[12]];
      for (int i = 0; i < 4; i++) rk[i] ^= tk[i];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rc = xt(rc);
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  assign pending = cipher_q.size();

  always @(posedge clk) begin
    logic [127:0] exp_ct;
    int errs;
    errs = 0;
    if (rst) begin
      cipher_key <= '0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgKeyHigh) cipher_key[127:64] <= cfg_data;
        else cipher_key[63:0] <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready)
        cipher_q.push_back(encrypt_block({s_axis_tdata[63:0], s_axis_tdata[127:64]},
                                         cipher_key));
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          errs = errs + 1;
        end else begin
          exp_ct = cipher_q.pop_front();
          if (m_axis_tdata[63:0] !== exp_ct[127:64]) begin
            $error("cipher_high expected %h actual %h", exp_ct[127:64], m_axis_tdata[63:0]);
            errs = errs + 1;
          end
          if (m_axis_tdata[127:64] !== exp_ct[63:0]) begin
            $error("cipher_low expected %h actual %h", exp_ct[63:0], m_axis_tdata[127:64]);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ----- tb/tb_aes128_block_encrypt_unit.sv -----
// ---------------------------------------------------------------------------
// AES-128 block encrypt unit testbench
// Directed and random plaintexts under several keys with random stalls on
// both streams; results are checked by the encrypt checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_aes128_block_encrypt_unit;
  import aes_pkg::*;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, m_axis_tready = 0, cfg_we = 0;
  logic s_axis_tready, m_axis_tvalid;
  logic [127:0] s_axis_tdata = '0, m_axis_tdata;
  logic [0:0] cfg_index = CfgKeyHigh;
  logic [63:0] cfg_data = '0;
  int fail_count, pending;
  int send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;

  always #5 clk = ~clk;

  aes128_block_encrypt_unit dut (.*);
  aes128_encrypt_checker chk (.*);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // receiver: long hold-off when asked, else random stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_key(logic [0:0] idx, logic [63:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // request stays up after acceptance until the next one or a drain
  task automatic send_block(logic [63:0] ph, logic [63:0] pl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {pl, ph};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_blocks(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_block(64'h0, rand64());
        1: send_block({64{1'b1}}, rand64());
        default: send_block(rand64(), rand64());
      endcase
    end
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 0;
    // reset key of all zeros, then extremes
    send_block(64'h0, 64'h0);
    send_block({64{1'b1}}, {64{1'b1}});
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();
    write_key(CfgKeyHigh, 64'h0001020304050607);
    write_key(CfgKeyLow, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(64'h0, 64'h0);
    send_block({64{1'b1}}, 64'h0);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    write_key(CfgKeyHigh, {64{1'b1}});
    write_key(CfgKeyLow, {64{1'b1}});
    send_block(64'h0, 64'h0);
    send_block({64{1'b1}}, {64{1'b1}});
    drain();
    // phases: free run after a long receiver hold-off, sparse sender, stalling receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      write_key(CfgKeyHigh, rand64());
      write_key(CfgKeyLow, rand64());
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 83 : 30) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 83 : 30) : 0;
      if (ph == 0) hold_cycles = 60;
      random_blocks(170);
      drain();
    end
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
